// ===== rtl/core/mwo_pkg.sv =====
// Package for the multi-waveform oscillator: wave shape and register codes,
// LFSR constants and the quarter-wave sine function used to build the ROM.
// No dependencies.
`default_nettype none

package mwo_pkg;

    localparam int SINE_TABLE_DEPTH_DEF = 256;
    localparam int PHASE_BITS_DEF       = 32;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [2:0] {
        WAVE_SINE     = 3'd0,
        WAVE_TRIANGLE = 3'd1,
        WAVE_SQUARE   = 3'd2,
        WAVE_SAWTOOTH = 3'd3,
        WAVE_NOISE    = 3'd4
    } wave_shape_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_WAVE_SHAPE = 2'd0,
        CFG_GAIN       = 2'd1,
        CFG_PHASE_STEP = 2'd2
    } cfg_reg_t;

    localparam logic [15:0] GAIN_RESET = 16'd19661;
    localparam logic [31:0] LFSR_SEED  = 32'h0000_ACE1;
    localparam logic [31:0] LFSR_TAPS  = 32'hD000_0001;

    localparam logic [63:0] SIN_C1 = 64'd1686629713;
    localparam logic [63:0] SIN_C3 = 64'd693598671;
    localparam logic [63:0] SIN_C5 = 64'd85569278;
    localparam logic [63:0] SIN_C7 = 64'd5026937;
    localparam logic [63:0] SIN_C9 = 64'd172271;

    // Sine of an angle given in Q2.30 quarter turns, rounded to unsigned Q0.15.
    function automatic logic [14:0] quarter_sine(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] r;
        x2 = (x * x) >> 30;
        t  = SIN_C9;
        t  = SIN_C7 - ((x2 * t) >> 30);
        t  = SIN_C5 - ((x2 * t) >> 30);
        t  = SIN_C3 - ((x2 * t) >> 30);
        t  = SIN_C1 - ((x2 * t) >> 30);
        r  = (x * t) >> 30;
        r  = (r + 64'd16384) >> 15;
        if (r > 64'd32767)
        begin
            r = 64'd32767;
        end
        return r[14:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mwo_sine_rom.sv =====
// Quarter-wave sine ROM with a registered read port.
// Depends on mwo_pkg for the table function.
`default_nettype none

module mwo_sine_rom
    import mwo_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
    localparam int AddrW = $clog2(SINE_TABLE_DEPTH + 1)
)
(
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [AddrW-1:0]  addr,
    output logic      [14:0]       data
);

    logic [14:0] rom_table [0:SINE_TABLE_DEPTH];

    for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++)
    begin : g_entry
        localparam logic [63:0] Angle = (64'(k) << 30) / SINE_TABLE_DEPTH;
        assign rom_table[k] = quarter_sine(Angle);
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            data <= rom_table[addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/multi_waveform_oscillator.sv =====
// Multi-waveform oscillator top level: phase accumulation by multiply, wave
// shaping and gain scaling on one shared signed multiplier.
// Depends on mwo_pkg and mwo_sine_rom.
//
//  Port group   Direction  Contents
//  s_*          in         sample_time, phase_offset
//  m_*          out        sample_out
//  cfg_*        in         wave_shape, gain, phase_step writes
//
// Items are taken one at a time; a sine item passes more steps than the other shapes.
// Each item uses the shared 33x33 multiplier in turn for its phase and gain products, a sine
// item also for its table index, followed by the registered ROM read.
// The result waits in an output register, and a new item is taken while it waits.
// If the previous result is still not taken, the item stalls in its last step.
// Reset clears the control state, restores register defaults and seeds the LFSR.
`default_nettype none

module multi_waveform_oscillator
    import mwo_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
    parameter int PHASE_BITS       = PHASE_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [47:0]            s_tdata,   // sample_time[31:0], phase_offset[47:32]
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic signed [15:0]          m_tdata,   // sample_out[15:0]
    input  wire logic                   cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int IdxW = $clog2(SINE_TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PHASE_MUL,
        ST_PHASE_SUM,
        ST_SHAPE,
        ST_ROM_READ,
        ST_SINE_SIGN,
        ST_GAIN_MUL,
        ST_ROUND
    } state_t;

    state_t               state_reg;
    wave_shape_t          wave_shape_reg;
    logic [15:0]          gain_reg;
    logic [31:0]          phase_step_reg;
    logic [31:0]          lfsr_reg;
    logic [31:0]          time_reg;
    logic [15:0]          offset_reg;
    logic signed [65:0]   prod_reg;
    logic [31:0]          phase_reg;
    logic signed [16:0]   wave_reg;
    logic                 out_valid_reg;

    logic signed [32:0]   mul_a;
    logic signed [32:0]   mul_b;
    logic signed [65:0]   mul_prod;
    logic [PHASE_BITS-1:0] phase_sum;
    logic [31:0]          phase_frac;
    logic [31:0]          lfsr_next;
    logic [30:0]          tri_diff;
    logic [15:0]          tri_mag;
    logic signed [16:0]   shape_value;
    logic [IdxW-1:0]      table_idx;
    logic [IdxW-1:0]      rom_addr;
    logic [14:0]          rom_data;
    logic signed [33:0]   round_sum;
    logic signed [17:0]   round_val;
    logic signed [15:0]   sat_val;
    logic                 result_load;

    always_comb
    begin
        unique case (state_reg)
            ST_SHAPE:
            begin
                mul_a = {3'b000, phase_reg[29:0]};
                mul_b = 33'(SINE_TABLE_DEPTH);
            end
            ST_GAIN_MUL:
            begin
                mul_a = {{16{wave_reg[16]}}, wave_reg};
                mul_b = {17'd0, gain_reg};
            end
            default:
            begin
                mul_a = {1'b0, time_reg};
                mul_b = {1'b0, phase_step_reg};
            end
        endcase
    end

    assign mul_prod  = mul_a * mul_b;
    assign phase_sum = prod_reg[PHASE_BITS-1:0]
                     + (PHASE_BITS'(offset_reg) << (PHASE_BITS - 16));

    if (PHASE_BITS >= 32)
    begin : g_phase_wide
        assign phase_frac = phase_sum[PHASE_BITS-1 -: 32];
    end
    else
    begin : g_phase_narrow
        assign phase_frac = {phase_sum, {(32 - PHASE_BITS){1'b0}}};
    end

    assign lfsr_next = {1'b0, lfsr_reg[31:1]} ^ (lfsr_reg[0] ? LFSR_TAPS : 32'd0);
    assign tri_diff  = 31'h4000_0000 - {1'b0, phase_reg[29:0]};
    assign tri_mag   = phase_reg[30] ? tri_diff[30:15] : {1'b0, phase_reg[29:15]};

    always_comb
    begin
        case (wave_shape_reg)
            WAVE_TRIANGLE:
            begin
                shape_value = phase_reg[31] ? -$signed({1'b0, tri_mag})
                                            : $signed({1'b0, tri_mag});
            end
            WAVE_SQUARE:
            begin
                shape_value = (phase_reg != 32'd0 && !phase_reg[31]) ? 17'sd32768
                                                                     : -17'sd32768;
            end
            WAVE_SAWTOOTH:
            begin
                shape_value = {phase_reg[31], phase_reg[31:16]};
            end
            WAVE_NOISE:
            begin
                shape_value = {~lfsr_next[31], ~lfsr_next[31], lfsr_next[30:16]};
            end
            default:
            begin
                shape_value = 17'sd0;
            end
        endcase
    end

    assign table_idx = prod_reg[30 +: IdxW];
    assign rom_addr  = phase_reg[30] ? IdxW'(SINE_TABLE_DEPTH) - table_idx : table_idx;

    mwo_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_sine_rom (
        .clk   (clk),
        .rd_en (state_reg == ST_ROM_READ),
        .addr  (rom_addr),
        .data  (rom_data)
    );

    assign round_sum = prod_reg[33:0] + 34'sd32768;
    assign round_val = round_sum[33:16];

    always_comb
    begin
        if (round_val > 18'sd32767)
        begin
            sat_val = 16'sh7FFF;
        end
        else if (round_val < -18'sd32768)
        begin
            sat_val = 16'sh8000;
        end
        else
        begin
            sat_val = round_val[15:0];
        end
    end

    assign result_load = (state_reg == ST_ROUND) && (!out_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_shape_reg <= WAVE_SINE;
            gain_reg       <= GAIN_RESET;
            phase_step_reg <= 32'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_WAVE_SHAPE: wave_shape_reg <= wave_shape_t'(cfg_wdata[2:0]);
                CFG_GAIN:       gain_reg       <= cfg_wdata[15:0];
                CFG_PHASE_STEP: phase_step_reg <= cfg_wdata[31:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            lfsr_reg      <= LFSR_SEED;
            time_reg      <= 32'd0;
            offset_reg    <= 16'd0;
            prod_reg      <= '0;
            phase_reg     <= 32'd0;
            wave_reg      <= '0;
            m_tdata       <= '0;
        end
        else
        begin
            if (result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        time_reg   <= s_tdata[31:0];
                        offset_reg <= s_tdata[47:32];
                        state_reg  <= ST_PHASE_MUL;
                    end
                end
                ST_PHASE_MUL:
                begin
                    prod_reg  <= mul_prod;
                    state_reg <= ST_PHASE_SUM;
                end
                ST_PHASE_SUM:
                begin
                    phase_reg <= phase_frac;
                    state_reg <= ST_SHAPE;
                end
                ST_SHAPE:
                begin
                    if (wave_shape_reg == WAVE_SINE)
                    begin
                        prod_reg  <= mul_prod;
                        state_reg <= ST_ROM_READ;
                    end
                    else
                    begin
                        wave_reg  <= shape_value;
                        state_reg <= ST_GAIN_MUL;
                        if (wave_shape_reg == WAVE_NOISE)
                        begin
                            lfsr_reg <= lfsr_next;
                        end
                    end
                end
                ST_ROM_READ:
                begin
                    state_reg <= ST_SINE_SIGN;
                end
                ST_SINE_SIGN:
                begin
                    wave_reg  <= phase_reg[31] ? -$signed({2'b00, rom_data})
                                               : $signed({2'b00, rom_data});
                    state_reg <= ST_GAIN_MUL;
                end
                ST_GAIN_MUL:
                begin
                    prod_reg  <= mul_prod;
                    state_reg <= ST_ROUND;
                end
                ST_ROUND:
                begin
                    if (result_load)
                    begin
                        m_tdata   <= sat_val;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    // One item at a time: after a transfer the input stays closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in progress");

    // The noise generator moves only when the noise shape is selected.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(lfsr_reg) |-> $past(wave_shape_reg) == WAVE_NOISE)
        else $error("noise LFSR advanced for a non-noise shape");

    // Leaving the final step always presents a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROUND && (!out_valid_reg || m_tready) |=> m_tvalid)
        else $error("finished item produced no result");

    // The final step waits only while the previous result is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROUND && !(out_valid_reg && !m_tready) |=> state_reg == ST_IDLE)
        else $error("sequencer stalled without output back-pressure");

endmodule

`default_nettype wire

// ===== sim/tb_multi_waveform_oscillator.sv =====
// Self-checking testbench for multi_waveform_oscillator: directed and random sample
// transfers with an in-bench fixed-point oscillator predictor and config phases.
// Depends on mwo_pkg and the multi_waveform_oscillator RTL.
module tb_multi_waveform_oscillator;
    import mwo_pkg::*;

    localparam int SETTLE_CYCLES   = 16;
    localparam int TAIL_CYCLES     = 16;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int MAX_REPORTS     = 10;
    localparam int PHASE_COUNT     = 25;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int QUARTER_DEPTH   = 256;
    localparam int FULL_SCALE      = 32768;

    localparam logic [2:0]  SHAPE_UNDEF_LO = 3'd5;
    localparam logic [2:0]  SHAPE_UNDEF_HI = 3'd7;
    localparam logic [15:0] RESET_GAIN     = 16'd19661;
    localparam logic [31:0] NOISE_SEED     = 32'h0000_ACE1;
    localparam logic [31:0] NOISE_TAPS     = 32'hD000_0001;

    localparam logic [63:0] TAYLOR_1 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_3 = 64'd693598671;
    localparam logic [63:0] TAYLOR_5 = 64'd85569278;
    localparam logic [63:0] TAYLOR_7 = 64'd5026937;
    localparam logic [63:0] TAYLOR_9 = 64'd172271;

    typedef enum logic [1:0] {
        OP_SAMPLE,
        OP_WRITE,
        OP_FLUSH
    } stim_kind_t;

    typedef struct {
        stim_kind_t  kind;
        logic [31:0] time_idx;
        logic [15:0] offset;
        int unsigned gap;
        cfg_reg_t    reg_sel;
        logic [31:0] value;
    } stim_op_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [47:0]           s_tdata   = '0;   // sample_time[31:0], phase_offset[47:32]
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic signed [15:0]    m_tdata;          // sample_out[15:0]
    logic                  cfg_we    = 1'b0;
    cfg_reg_t              cfg_addr  = CFG_WAVE_SHAPE;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    stim_op_t           stim_ops[$];
    logic signed [15:0] expected_samples[$];
    int                 sine_quarter[0:QUARTER_DEPTH];

    logic [2:0]  shape_reg   = WAVE_SINE;
    logic [15:0] gain_reg    = RESET_GAIN;
    logic [31:0] step_reg    = '0;
    logic [31:0] noise_state = NOISE_SEED;

    bit          burst_mode   = 1'b0;
    int unsigned gap_left     = 0;
    bit          gap_drawn    = 1'b0;
    int unsigned settle_count = 0;
    int unsigned stall_left   = 0;
    int unsigned results_seen = 0;
    int unsigned fault_count  = 0;
    int unsigned idle_cycles  = 0;

    multi_waveform_oscillator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Quarter-wave sine at k/QUARTER_DEPTH of a quarter turn, odd Taylor series in Q2.30.
    function automatic int sine_entry(input int k);
        logic [63:0] ang;
        logic [63:0] ang2;
        logic [63:0] acc;
        ang  = (64'(k) << 30) / QUARTER_DEPTH;
        ang2 = (ang * ang) >> 30;
        acc  = TAYLOR_9;
        acc  = TAYLOR_7 - ((ang2 * acc) >> 30);
        acc  = TAYLOR_5 - ((ang2 * acc) >> 30);
        acc  = TAYLOR_3 - ((ang2 * acc) >> 30);
        acc  = TAYLOR_1 - ((ang2 * acc) >> 30);
        acc  = (ang * acc) >> 30;
        acc  = (acc + 64'd16384) >> 15;
        if (acc > 64'd32767)
        begin
            acc = 64'd32767;
        end
        return int'(acc);
    endfunction

    function automatic void apply_write(input cfg_reg_t sel, input logic [31:0] v);
        case (sel)
            CFG_WAVE_SHAPE: shape_reg = v[2:0];
            CFG_GAIN:       gain_reg  = v[15:0];
            CFG_PHASE_STEP: step_reg  = v;
            default: ;
        endcase
    endfunction

    function automatic logic signed [15:0] predict_sample(input logic [31:0] t,
                                                          input logic [15:0] off);
        logic [31:0] p;
        logic [31:0] f;
        logic [31:0] ramp;
        int          idx;
        int          w;
        longint      scaled;
        p = t * step_reg + {off, 16'h0000};
        f = {2'b00, p[29:0]};
        case (shape_reg)
            WAVE_SINE:
            begin
                idx = int'((64'(f) * QUARTER_DEPTH) >> 30);
                if (p[30])
                begin
                    idx = QUARTER_DEPTH - idx;
                end
                w = p[31] ? -sine_quarter[idx] : sine_quarter[idx];
            end
            WAVE_TRIANGLE:
            begin
                ramp = p[30] ? (32'h4000_0000 - f) >> 15 : f >> 15;
                w    = p[31] ? -int'(ramp) : int'(ramp);
            end
            WAVE_SQUARE:
            begin
                w = (p != 32'h0 && !p[31]) ? FULL_SCALE : -FULL_SCALE;
            end
            WAVE_SAWTOOTH:
            begin
                w = int'($signed(p[31:16]));
            end
            WAVE_NOISE:
            begin
                noise_state = noise_state[0] ? (noise_state >> 1) ^ NOISE_TAPS
                                             : noise_state >> 1;
                w = int'(noise_state[31:16]) - FULL_SCALE;
            end
            default:
            begin
                w = 0;
            end
        endcase
        scaled = (longint'(w) * longint'(gain_reg) + 64'sd32768) >>> 16;
        if (scaled > 32767)
        begin
            scaled = 32767;
        end
        else if (scaled < -32768)
        begin
            scaled = -32768;
        end
        return 16'(scaled);
    endfunction

    task automatic add_sample(input logic [31:0] t, input logic [15:0] off);
        stim_op_t op;
        op.kind     = OP_SAMPLE;
        op.time_idx = t;
        op.offset   = off;
        op.gap      = burst_mode ? 0 : $urandom_range(0, 8);
        op.reg_sel  = CFG_WAVE_SHAPE;
        op.value    = '0;
        stim_ops.push_back(op);
    endtask

    task automatic add_write(input cfg_reg_t sel, input logic [31:0] v);
        stim_op_t op;
        op.kind     = OP_WRITE;
        op.time_idx = '0;
        op.offset   = '0;
        op.gap      = 0;
        op.reg_sel  = sel;
        op.value    = v;
        stim_ops.push_back(op);
    endtask

    task automatic add_flush();
        stim_op_t op;
        op.kind     = OP_FLUSH;
        op.time_idx = '0;
        op.offset   = '0;
        op.gap      = 0;
        op.reg_sel  = CFG_WAVE_SHAPE;
        op.value    = '0;
        stim_ops.push_back(op);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : driver
        stim_op_t         op;
        logic             nxt_valid;
        logic [47:0]      nxt_data;
        logic             nxt_we;
        cfg_reg_t         nxt_addr;
        logic [31:0]      nxt_wdata;
        if (!rst_n)
        begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            cfg_we    <= 1'b0;
            cfg_addr  <= CFG_WAVE_SHAPE;
            cfg_wdata <= '0;
        end
        else
        begin
            nxt_valid = s_tvalid;
            nxt_data  = s_tdata;
            nxt_we    = 1'b0;
            nxt_addr  = cfg_addr;
            nxt_wdata = cfg_wdata;
            if (s_tvalid && s_tready)
            begin
                expected_samples.push_back(predict_sample(s_tdata[31:0], s_tdata[47:32]));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && stim_ops.size() != 0)
            begin
                op = stim_ops[0];
                if (op.kind == OP_SAMPLE)
                begin
                    if (!gap_drawn)
                    begin
                        gap_left  = op.gap;
                        gap_drawn = 1'b1;
                    end
                    if (gap_left != 0)
                    begin
                        gap_left--;
                    end
                    else
                    begin
                        nxt_valid = 1'b1;
                        nxt_data  = {op.offset, op.time_idx};
                        gap_drawn = 1'b0;
                        void'(stim_ops.pop_front());
                    end
                end
                else if (expected_samples.size() != 0)
                begin
                    settle_count = 0;
                end
                else if (settle_count < SETTLE_CYCLES)
                begin
                    settle_count++;
                end
                else
                begin
                    // The block is idle: registers may change now.
                    settle_count = 0;
                    if (op.kind == OP_WRITE)
                    begin
                        nxt_we    = 1'b1;
                        nxt_addr  = op.reg_sel;
                        nxt_wdata = op.value;
                        apply_write(op.reg_sel, op.value);
                    end
                    void'(stim_ops.pop_front());
                end
            end
            s_tvalid  <= nxt_valid;
            s_tdata   <= nxt_data;
            cfg_we    <= nxt_we;
            cfg_addr  <= nxt_addr;
            cfg_wdata <= nxt_wdata;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        logic signed [15:0] want;
        logic               nxt_ready;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_samples.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                    begin
                        $display("Unexpected transfer: sample_out %0d", m_tdata);
                    end
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (m_tdata !== want)
                    begin
                        fault_count++;
                        if (fault_count <= MAX_REPORTS)
                        begin
                            $display("Mismatch on result %0d: sample_out expected %0d, got %0d",
                                     results_seen, want, m_tdata);
                        end
                    end
                end
                results_seen++;
                stall_left = (results_seen % 200 < 40) ? 0 : $urandom_range(0, 8);
                nxt_ready  = (stall_left == 0);
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                nxt_ready = (stall_left == 0);
            end
            else
            begin
                nxt_ready = 1'b1;
            end
            m_tready <= nxt_ready;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int          k;
        int          phase;
        int          i;
        logic [31:0] base_time;
        logic [31:0] t;
        logic [31:0] v;
        for (k = 0; k <= QUARTER_DEPTH; k++)
        begin
            sine_quarter[k] = sine_entry(k);
        end

        // Register defaults first, then full gain and the largest step.
        add_sample(32'h0, 16'h0000);
        add_sample(32'h0, 16'h4000);
        add_write(CFG_GAIN, 32'h0000_FFFF);
        add_write(CFG_PHASE_STEP, 32'hFFFF_FFFF);
        add_sample(32'hFFFF_FFFF, 16'h0000);
        add_sample(32'h0, 16'h4000);
        add_sample(32'h0, 16'h8000);
        add_sample(32'h1, 16'hFFFF);
        add_write(CFG_WAVE_SHAPE, 32'(WAVE_TRIANGLE));
        add_sample(32'h0, 16'h4000);
        add_sample(32'h0, 16'hC000);
        add_sample(32'h0, 16'h2000);
        // Square at a quarter turn is plus one full scale and must saturate.
        add_write(CFG_WAVE_SHAPE, 32'(WAVE_SQUARE));
        add_sample(32'h0, 16'h0000);
        add_sample(32'h0, 16'h4000);
        add_sample(32'h0, 16'h8000);
        add_write(CFG_WAVE_SHAPE, 32'(WAVE_SAWTOOTH));
        add_sample(32'h0, 16'h8000);
        add_sample(32'h0, 16'h7FFF);
        add_sample(32'h0, 16'hFFFF);
        add_write(CFG_WAVE_SHAPE, 32'(WAVE_NOISE));
        add_sample(32'h0, 16'h0000);
        add_sample(32'hFFFF_FFFF, 16'hFFFF);
        add_sample(32'h1234_5678, 16'h1234);
        // Undefined shapes give zero and leave the noise generator alone.
        add_write(CFG_WAVE_SHAPE, 32'(SHAPE_UNDEF_LO));
        add_sample(32'h0, 16'h4000);
        add_write(CFG_WAVE_SHAPE, 32'(SHAPE_UNDEF_HI));
        add_sample(32'h0, 16'h4000);
        add_write(CFG_WAVE_SHAPE, 32'(WAVE_NOISE));
        add_write(CFG_GAIN, 32'h0);
        add_sample(32'h0, 16'h4000);

        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            burst_mode = (phase % 4 == 3);
            case ($urandom_range(0, 9))
                8:       v = 32'($urandom_range(SHAPE_UNDEF_LO, SHAPE_UNDEF_HI));
                9:       v = 32'(WAVE_NOISE);
                default: v = 32'($urandom_range(WAVE_SINE, WAVE_NOISE));
            endcase
            add_write(CFG_WAVE_SHAPE, v);
            case ($urandom_range(0, 5))
                0:       v = 32'h0;
                1:       v = 32'h0000_FFFF;
                2:       v = 32'h1;
                default: v = $urandom & 32'h0000_FFFF;
            endcase
            add_write(CFG_GAIN, v);
            case ($urandom_range(0, 5))
                0:       v = 32'h0;
                1:       v = 32'hFFFF_FFFF;
                2:       v = $urandom_range(1, 1 << 20);
                default: v = $urandom;
            endcase
            add_write(CFG_PHASE_STEP, v);
            base_time = $urandom;
            for (i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                case ($urandom_range(0, 5))
                    0:       t = $urandom;
                    1:       t = $urandom_range(0, 15);
                    default: t = base_time + i;
                endcase
                add_sample(t, 16'($urandom));
                if (i == ITEMS_PER_PHASE / 2 && phase % 3 == 1)
                begin
                    add_flush();
                end
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (!(stim_ops.size() == 0 && !s_tvalid && expected_samples.size() == 0)
               && idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("** multi_waveform_oscillator: FAILED **");
        end
        else
        begin
            repeat (TAIL_CYCLES) @(posedge clk);
            if (fault_count == 0 && expected_samples.size() == 0)
            begin
                $display("** multi_waveform_oscillator: PASSED **");
            end
            else
            begin
                $display("** multi_waveform_oscillator: FAILED **");
            end
        end
        $finish;
    end

endmodule
